// File: hdl/rrfq_pkg.sv
package rrfq_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned PtrW       = $clog2(QueueDepth);
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);
  localparam int unsigned TimeW      = 16;
  localparam int unsigned TagW       = 16;

  typedef enum logic [1:0] {
    ActAdd    = 2'd0,
    ActRemove = 2'd1,
    ActExec   = 2'd2,
    ActIdle   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StFull  = 2'd1,
    StEmpty = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    SIdle,
    SIssue,
    SCalc,
    SUpdate
  } state_e;

  typedef struct packed {
    logic             mark;
    logic [TimeW-1:0] quantum;
    logic [TimeW-1:0] burst;
    logic [TagW-1:0]  tag;
  } rec_t;

  localparam int unsigned RecW = $bits(rec_t);

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic issue;
    logic calc;
    logic update;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

// File: hdl/rrfq_ram.sv
module rrfq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/rrfq_ctrl.sv
module rrfq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  rrfq_pkg::sts_t  sts_i,
  output rrfq_pkg::cmd_t  cmd_o
);

  rrfq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rrfq_pkg::SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      rrfq_pkg::SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = rrfq_pkg::SIssue;
        end
      end
      rrfq_pkg::SIssue: begin
        cmd_o.issue = 1'b1;
        state_d     = rrfq_pkg::SCalc;
      end
      rrfq_pkg::SCalc: begin
        cmd_o.calc = 1'b1;
        state_d    = rrfq_pkg::SUpdate;
      end
      rrfq_pkg::SUpdate: begin
        // hold until the output register can take the result
        if (sts_i.out_free) begin
          cmd_o.update = 1'b1;
          state_d      = rrfq_pkg::SIdle;
        end
      end
      default: state_d = rrfq_pkg::SIdle;
    endcase
  end

endmodule

// File: hdl/rrfq_dp.sv
module rrfq_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rrfq_pkg::cmd_t               cmd_i,
  output rrfq_pkg::sts_t               sts_o,
  input  logic                         cfg_we_i,
  input  logic                         cfg_wdata_i,
  input  logic [1:0]                   action_i,
  input  logic [rrfq_pkg::TagW-1:0]    new_tag_i,
  input  logic [rrfq_pkg::TimeW-1:0]   new_burst_i,
  input  logic [rrfq_pkg::TimeW-1:0]   new_quantum_i,
  input  logic [rrfq_pkg::TimeW-1:0]   io_limit_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [rrfq_pkg::TimeW-1:0]   time_used_o,
  output logic                         move_queue_o,
  output logic [rrfq_pkg::TagW-1:0]    head_tag_o,
  output logic [rrfq_pkg::TimeW-1:0]   head_burst_o,
  output logic [rrfq_pkg::TimeW-1:0]   head_quantum_o,
  output logic [rrfq_pkg::CntW-1:0]    entry_count_o,
  output logic [1:0]                   status_o
);

  function automatic logic [rrfq_pkg::PtrW-1:0] next_ptr(input logic [rrfq_pkg::PtrW-1:0] p);
    if (p == rrfq_pkg::PtrW'(rrfq_pkg::QueueDepth - 1)) begin
      return '0;
    end
    return p + rrfq_pkg::PtrW'(1);
  endfunction

  // request fields
  rrfq_pkg::action_e                act_q;
  logic [rrfq_pkg::TagW-1:0]        tag_q;
  logic [rrfq_pkg::TimeW-1:0]       burst_q, quant_q, lim_q;

  logic                             mode_q;
  logic [rrfq_pkg::PtrW-1:0]        head_q, head_d, tail_q, tail_d;
  logic [rrfq_pkg::CntW-1:0]        cnt_q, cnt_d;
  rrfq_pkg::status_e                status_q, status_d;
  logic                             exec_q, exec_d;
  logic                             fresh_q, fresh_d;
  logic [rrfq_pkg::TimeW-1:0]       run_q, run_d;

  logic                             out_valid_q;
  logic [rrfq_pkg::TimeW-1:0]       time_q;
  rrfq_pkg::rec_t                   head_rec_q, head_rec_d;
  logic [rrfq_pkg::CntW-1:0]        out_cnt_q;
  rrfq_pkg::status_e                out_status_q;

  logic                             ram_we, ram_re;
  logic [rrfq_pkg::PtrW-1:0]        ram_waddr, ram_raddr;
  rrfq_pkg::rec_t                   ram_wdata, ram_rdata, upd_rec;
  logic [rrfq_pkg::RecW-1:0]        ram_rdata_raw;

  logic                             empty;
  logic [rrfq_pkg::TimeW-1:0]       limit;
  logic [rrfq_pkg::TimeW-1:0]       new_burst, new_quant;

  rrfq_ram #(
    .Width(rrfq_pkg::RecW),
    .Depth(rrfq_pkg::QueueDepth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata_raw)
  );

  assign ram_rdata = rrfq_pkg::rec_t'(ram_rdata_raw);
  assign empty     = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q   <= rrfq_pkg::action_e'(action_i);
      tag_q   <= new_tag_i;
      burst_q <= new_burst_i;
      quant_q <= new_quantum_i;
      lim_q   <= io_limit_i;
    end
  end

  // queue bookkeeping, RAM port use and the run time
  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    cnt_d     = cnt_q;
    status_d  = status_q;
    exec_d    = exec_q;
    fresh_d   = fresh_q;
    run_d     = run_q;
    ram_we    = 1'b0;
    ram_waddr = tail_q;
    ram_wdata = '0;
    ram_re    = cmd_i.issue;
    ram_raddr = (act_q == rrfq_pkg::ActRemove && !empty) ? next_ptr(head_q) : head_q;
    limit     = '0;

    if (cmd_i.issue) begin
      status_d = rrfq_pkg::StOk;
      exec_d   = 1'b0;
      fresh_d  = 1'b0;
      unique case (act_q)
        rrfq_pkg::ActAdd: begin
          if (cnt_q == rrfq_pkg::CntW'(rrfq_pkg::QueueDepth)) begin
            status_d = rrfq_pkg::StFull;
          end else begin
            ram_we            = 1'b1;
            ram_waddr         = tail_q;
            ram_wdata.tag     = tag_q;
            ram_wdata.burst   = burst_q;
            ram_wdata.quantum = quant_q;
            ram_wdata.mark    = 1'b0;
            tail_d            = next_ptr(tail_q);
            cnt_d             = cnt_q + rrfq_pkg::CntW'(1);
            fresh_d           = empty;
          end
        end
        rrfq_pkg::ActRemove: begin
          if (empty) begin
            status_d = rrfq_pkg::StEmpty;
          end else begin
            head_d = next_ptr(head_q);
            cnt_d  = cnt_q - rrfq_pkg::CntW'(1);
          end
        end
        rrfq_pkg::ActExec: begin
          if (empty) begin
            status_d = rrfq_pkg::StEmpty;
          end else begin
            exec_d = 1'b1;
          end
        end
        rrfq_pkg::ActIdle: begin
          if (empty) begin
            status_d = rrfq_pkg::StEmpty;
          end
        end
        default: status_d = rrfq_pkg::StOk;
      endcase
    end

    if (cmd_i.calc) begin
      if (!mode_q) begin
        limit = ram_rdata.quantum;
        if (lim_q != '0 && lim_q < limit) begin
          limit = lim_q;
        end
      end else begin
        limit = (lim_q != '0) ? lim_q : ram_rdata.burst;
      end
      run_d = (ram_rdata.burst < limit) ? ram_rdata.burst : limit;
      if (!exec_q) begin
        run_d = '0;
      end
    end

    if (cmd_i.update && exec_q) begin
      ram_we    = 1'b1;
      ram_waddr = head_q;
      ram_wdata = upd_rec;
    end
  end

  // head record after an execute
  always_comb begin
    new_burst = ram_rdata.burst - run_q;
    new_quant = mode_q ? ram_rdata.quantum : ram_rdata.quantum - run_q;
    upd_rec         = ram_rdata;
    upd_rec.burst   = new_burst;
    upd_rec.quantum = new_quant;
    upd_rec.mark    = !mode_q && (new_burst != '0) && (new_quant == '0);
  end

  always_comb begin
    if (empty) begin
      head_rec_d = '0;
    end else if (fresh_q) begin
      head_rec_d.tag     = tag_q;
      head_rec_d.burst   = burst_q;
      head_rec_d.quantum = quant_q;
      head_rec_d.mark    = 1'b0;
    end else if (exec_q) begin
      head_rec_d = upd_rec;
    end else begin
      head_rec_d = ram_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      status_q    <= rrfq_pkg::StOk;
      exec_q      <= 1'b0;
      fresh_q     <= 1'b0;
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      head_q   <= head_d;
      tail_q   <= tail_d;
      cnt_q    <= cnt_d;
      status_q <= status_d;
      exec_q   <= exec_d;
      fresh_q  <= fresh_d;
      run_q    <= run_d;
      if (cmd_i.update) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      time_q       <= run_q;
      head_rec_q   <= head_rec_d;
      out_cnt_q    <= cnt_q;
      out_status_q <= status_q;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign time_used_o    = time_q;
  assign move_queue_o   = head_rec_q.mark;
  assign head_tag_o     = head_rec_q.tag;
  assign head_burst_o   = head_rec_q.burst;
  assign head_quantum_o = head_rec_q.quantum;
  assign entry_count_o  = out_cnt_q;
  assign status_o       = out_status_q;

endmodule

// File: hdl/rr_fcfs_ready_queue_unit.sv
// Channel   Handshake                  Payload
// in        in_valid_i / in_ready_o    action_i, new_tag_i, new_burst_i, new_quantum_i,
//                                      io_limit_i
// out       out_valid_o / out_ready_i  time_used_o, move_queue_o, head_tag_o, head_burst_o,
//                                      head_quantum_o, entry_count_o, status_o
// cfg       cfg_we_i                   cfg_wdata_i (fcfs_mode)
//
// A request passes through accept, RAM read/queue update, run-time calc, and write-back
// and result load, in that order; the next request is accepted only after write-back.
// Reset empties the queue (pointers and count cleared); RAM contents are not cleared.
// A result waiting in the output register does not block the next request; the
// write-back cycle stalls only if the previous result is still not taken.
module rr_fcfs_ready_queue_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   action_i,
  input  logic [rrfq_pkg::TagW-1:0]    new_tag_i,
  input  logic [rrfq_pkg::TimeW-1:0]   new_burst_i,
  input  logic [rrfq_pkg::TimeW-1:0]   new_quantum_i,
  input  logic [rrfq_pkg::TimeW-1:0]   io_limit_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [rrfq_pkg::TimeW-1:0]   time_used_o,
  output logic                         move_queue_o,
  output logic [rrfq_pkg::TagW-1:0]    head_tag_o,
  output logic [rrfq_pkg::TimeW-1:0]   head_burst_o,
  output logic [rrfq_pkg::TimeW-1:0]   head_quantum_o,
  output logic [rrfq_pkg::CntW-1:0]    entry_count_o,
  output logic [1:0]                   status_o
);

  rrfq_pkg::cmd_t cmd;
  rrfq_pkg::sts_t sts;

  rrfq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  rrfq_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .action_i      (action_i),
    .new_tag_i     (new_tag_i),
    .new_burst_i   (new_burst_i),
    .new_quantum_i (new_quantum_i),
    .io_limit_i    (io_limit_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .time_used_o   (time_used_o),
    .move_queue_o  (move_queue_o),
    .head_tag_o    (head_tag_o),
    .head_burst_o  (head_burst_o),
    .head_quantum_o(head_quantum_o),
    .entry_count_o (entry_count_o),
    .status_o      (status_o)
  );

endmodule

// File: tb/sv/tb_rr_fcfs_ready_queue_unit.sv
module tb_rr_fcfs_ready_queue_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import rrfq_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseCount = 8;
  localparam int unsigned PhaseItems = 215;
  localparam int unsigned MaxPrints  = 100;

  typedef struct packed {
    logic [TimeW-1:0] time_used;
    logic             mark;
    logic [TagW-1:0]  tag;
    logic [TimeW-1:0] burst;
    logic [TimeW-1:0] quantum;
    logic [CntW-1:0]  count;
    status_e          status;
  } sched_res_t;

  typedef struct {
    bit               is_cfg;
    bit               mode;
    action_e          act;
    logic [TagW-1:0]  tag;
    logic [TimeW-1:0] burst;
    logic [TimeW-1:0] quantum;
    logic [TimeW-1:0] io;
    int unsigned      reps;
    bit               typed;
    sched_res_t       want;
  } plan_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         action_i;
  logic [TagW-1:0]    new_tag_i;
  logic [TimeW-1:0]   new_burst_i;
  logic [TimeW-1:0]   new_quantum_i;
  logic [TimeW-1:0]   io_limit_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [TimeW-1:0]   time_used_o;
  logic               move_queue_o;
  logic [TagW-1:0]    head_tag_o;
  logic [TimeW-1:0]   head_burst_o;
  logic [TimeW-1:0]   head_quantum_o;
  logic [CntW-1:0]    entry_count_o;
  logic [1:0]         status_o;

  rr_fcfs_ready_queue_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .new_tag_i      (new_tag_i),
    .new_burst_i    (new_burst_i),
    .new_quantum_i  (new_quantum_i),
    .io_limit_i     (io_limit_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .time_used_o    (time_used_o),
    .move_queue_o   (move_queue_o),
    .head_tag_o     (head_tag_o),
    .head_burst_o   (head_burst_o),
    .head_quantum_o (head_quantum_o),
    .entry_count_o  (entry_count_o),
    .status_o       (status_o)
  );

  // mirror of the ready queue
  rec_t        ready_mem [QueueDepth];
  int unsigned ready_head;
  int unsigned ready_tail;
  int unsigned ready_count;
  bit          fcfs_mode;

  sched_res_t  pending_results [$];
  plan_row_t   plan [$];

  int unsigned cycles;
  int unsigned mismatches;
  bit          no_idle;
  int unsigned n_req, n_full, n_empty, n_marked, n_exec_rr, n_exec_fcfs;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycles <= cycles + 1;

  initial begin
    wait (cycles >= CycleLimit);
    $display("timeout after %0d cycles, %0d results outstanding", cycles,
             pending_results.size());
    $display("rr_fcfs_ready_queue_unit test failed");
    $finish;
  end

  function automatic int unsigned wrap_next(int unsigned p);
    return (p + 1 >= QueueDepth) ? 0 : p + 1;
  endfunction

  // one request applied to the mirror; returns the result it should produce
  function automatic sched_res_t advance_queue(action_e act, logic [TagW-1:0] tag,
                                               logic [TimeW-1:0] burst,
                                               logic [TimeW-1:0] quantum,
                                               logic [TimeW-1:0] io);
    sched_res_t       r;
    rec_t             e;
    logic [TimeW-1:0] cap;
    logic [TimeW-1:0] run;
    r = '0;
    r.status = StOk;
    if (act == ActAdd) begin
      if (ready_count >= QueueDepth) begin
        r.status = StFull;
      end else begin
        e.mark = 1'b0;
        e.tag = tag;
        e.burst = burst;
        e.quantum = quantum;
        ready_mem[ready_tail] = e;
        ready_tail = wrap_next(ready_tail);
        ready_count++;
      end
    end else if (ready_count == 0) begin
      r.status = StEmpty;
    end else if (act == ActRemove) begin
      ready_head = wrap_next(ready_head);
      ready_count--;
    end else if (act == ActExec) begin
      e = ready_mem[ready_head];
      if (!fcfs_mode) begin
        cap = e.quantum;
        if (io != 0 && io < cap) cap = io;
        run = (e.burst < cap) ? e.burst : cap;
        e.burst = e.burst - run;
        e.quantum = e.quantum - run;
        e.mark = (e.burst != 0) && (e.quantum == 0);
      end else begin
        e.mark = 1'b0;
        run = (io != 0 && io < e.burst) ? io : e.burst;
        e.burst = e.burst - run;
      end
      ready_mem[ready_head] = e;
      r.time_used = run;
    end
    if (ready_count != 0) begin
      r.mark = ready_mem[ready_head].mark;
      r.tag = ready_mem[ready_head].tag;
      r.burst = ready_mem[ready_head].burst;
      r.quantum = ready_mem[ready_head].quantum;
    end
    r.count = CntW'(ready_count);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatches++;
    if (mismatches <= MaxPrints)
      $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h", cycles, what, got, want);
  endtask

  // result checker
  always @(posedge clk_i) begin
    sched_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending", head_tag_o, 0);
      end else begin
        want = pending_results.pop_front();
        if (time_used_o !== want.time_used)
          report_mismatch("time_used", time_used_o, want.time_used);
        if (move_queue_o !== want.mark)
          report_mismatch("move_queue", move_queue_o, want.mark);
        if (head_tag_o !== want.tag)
          report_mismatch("head_tag", head_tag_o, want.tag);
        if (head_burst_o !== want.burst)
          report_mismatch("head_burst", head_burst_o, want.burst);
        if (head_quantum_o !== want.quantum)
          report_mismatch("head_quantum", head_quantum_o, want.quantum);
        if (entry_count_o !== want.count)
          report_mismatch("entry_count", entry_count_o, want.count);
        if (status_o !== want.status)
          report_mismatch("status", status_o, want.status);
      end
    end
  end

  // result side back-pressure
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (no_idle) begin
        out_ready_i = 1'b1;
      end else if (stall_left > 0) begin
        out_ready_i = 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 5) == 0) begin
        out_ready_i = 1'b0;
        stall_left = $urandom_range(1, 8) - 1;
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  task automatic issue(action_e act, logic [TagW-1:0] tag, logic [TimeW-1:0] burst,
                       logic [TimeW-1:0] quantum, logic [TimeW-1:0] io,
                       bit typed, sched_res_t want);
    int unsigned gap;
    sched_res_t  r;
    @(negedge clk_i);
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    action_i = act;
    new_tag_i = tag;
    new_burst_i = burst;
    new_quantum_i = quantum;
    io_limit_i = io;
    do @(posedge clk_i); while (!in_ready_o);
    r = advance_queue(act, tag, burst, quantum, io);
    pending_results.push_back(typed ? want : r);
    n_req++;
    if (r.status == StFull) n_full++;
    if (r.status == StEmpty) n_empty++;
    if (r.mark) n_marked++;
    if (act == ActExec && r.status == StOk) begin
      if (fcfs_mode) n_exec_fcfs++;
      else n_exec_rr++;
    end
  endtask

  // drop valid, then wait for every outstanding result plus some margin
  task automatic wait_quiet(int unsigned extra);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_mode(bit mode);
    wait_quiet(8);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = mode;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    fcfs_mode = mode;
  endtask

  function automatic sched_res_t res(logic [TimeW-1:0] used, logic mark, logic [TagW-1:0] tag,
                                     logic [TimeW-1:0] burst, logic [TimeW-1:0] quantum,
                                     int unsigned count, status_e st);
    sched_res_t r;
    r.time_used = used;
    r.mark = mark;
    r.tag = tag;
    r.burst = burst;
    r.quantum = quantum;
    r.count = CntW'(count);
    r.status = st;
    return r;
  endfunction

  function automatic plan_row_t req(action_e act, logic [TagW-1:0] tag,
                                    logic [TimeW-1:0] burst, logic [TimeW-1:0] quantum,
                                    logic [TimeW-1:0] io, int unsigned reps = 1);
    plan_row_t p;
    p.is_cfg = 1'b0;
    p.mode = 1'b0;
    p.act = act;
    p.tag = tag;
    p.burst = burst;
    p.quantum = quantum;
    p.io = io;
    p.reps = reps;
    p.typed = 1'b0;
    p.want = '0;
    return p;
  endfunction

  function automatic plan_row_t typed_req(plan_row_t p, sched_res_t want);
    p.typed = 1'b1;
    p.want = want;
    return p;
  endfunction

  function automatic plan_row_t cfg_row(bit mode);
    plan_row_t p;
    p = req(ActIdle, 0, 0, 0, 0, 0);
    p.is_cfg = 1'b1;
    p.mode = mode;
    return p;
  endfunction

  // time values: mostly small so quanta and bursts run out, plus the extremes
  function automatic logic [TimeW-1:0] pick_time();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return 1;
    if (r == 2) return '1;
    if (r <= 6) return TimeW'($urandom_range(1, 64));
    return TimeW'($urandom);
  endfunction

  function automatic action_e pick_action(int unsigned kind);
    int unsigned r;
    int unsigned w_add, w_rem;
    r = $urandom_range(0, 99);
    case (kind)
      0: begin w_add = 55; w_rem = 15; end
      1: begin w_add = 35; w_rem = 25; end
      default: begin w_add = 15; w_rem = 45; end
    endcase
    if (r < w_add) return ActAdd;
    if (r < w_add + w_rem) return ActRemove;
    if (r < 95) return ActExec;
    return ActIdle;
  endfunction

  initial begin
    cycles = 0;
    mismatches = 0;
    no_idle = 1'b0;
    n_req = 0;
    n_full = 0;
    n_empty = 0;
    n_marked = 0;
    n_exec_rr = 0;
    n_exec_fcfs = 0;
    ready_head = 0;
    ready_tail = 0;
    ready_count = 0;
    fcfs_mode = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 1'b0;
    in_valid_i = 1'b0;
    action_i = ActIdle;
    new_tag_i = '0;
    new_burst_i = '0;
    new_quantum_i = '0;
    io_limit_i = '0;

    // empty queue, extremes, then a round-robin record run down past its quantum
    plan.push_back(typed_req(req(ActRemove, 0, 0, 0, 0), res(0, 0, 0, 0, 0, 0, StEmpty)));
    plan.push_back(typed_req(req(ActExec, '1, '1, '1, '1), res(0, 0, 0, 0, 0, 0, StEmpty)));
    plan.push_back(typed_req(req(ActIdle, 0, 0, 0, 0), res(0, 0, 0, 0, 0, 0, StEmpty)));
    plan.push_back(typed_req(req(ActAdd, '1, '1, '1, 0),
                             res(0, 0, '1, '1, '1, 1, StOk)));
    plan.push_back(typed_req(req(ActExec, 0, 0, 0, 0), res('1, 0, '1, 0, 0, 1, StOk)));
    plan.push_back(typed_req(req(ActRemove, 0, 0, 0, 0), res(0, 0, 0, 0, 0, 0, StOk)));
    plan.push_back(typed_req(req(ActAdd, 0, 0, 0, '1), res(0, 0, 0, 0, 0, 1, StOk)));
    plan.push_back(typed_req(req(ActExec, 0, 0, 0, '1), res(0, 0, 0, 0, 0, 1, StOk)));
    plan.push_back(typed_req(req(ActIdle, 0, 0, 0, 0), res(0, 0, 0, 0, 0, 1, StOk)));
    plan.push_back(typed_req(req(ActRemove, 0, 0, 0, 0), res(0, 0, 0, 0, 0, 0, StOk)));
    plan.push_back(req(ActAdd, 16'h1234, 16'd100, 16'd30, 0));
    plan.push_back(req(ActExec, 0, 0, 0, 16'd5));
    plan.push_back(req(ActExec, 0, 0, 0, 0));
    plan.push_back(req(ActExec, 0, 0, 0, 16'd1));
    // fill to the brim, then one more add that must be refused
    plan.push_back(req(ActAdd, 16'hA500, 16'h00FF, 16'h0008, 0, QueueDepth - 1));
    plan.push_back(req(ActAdd, 16'h5A5A, 16'h0001, 16'h0001, 0));
    plan.push_back(cfg_row(1'b1));
    plan.push_back(req(ActExec, 0, 0, 0, 0));
    plan.push_back(req(ActRemove, 0, 0, 0, 0));
    plan.push_back(req(ActExec, 0, 0, 0, 16'd3));
    plan.push_back(req(ActExec, 0, 0, 0, 0));
    plan.push_back(cfg_row(1'b0));
    plan.push_back(req(ActExec, 0, 0, 0, 0));
    plan.push_back(req(ActIdle, '1, '1, '1, '1));

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        write_mode(plan[i].mode);
      end else begin
        for (int unsigned k = 0; k < plan[i].reps; k++)
          issue(plan[i].act, plan[i].tag + TagW'(k), plan[i].burst, plan[i].quantum,
                plan[i].io, plan[i].typed, plan[i].want);
      end
    end

    for (int unsigned p = 0; p < PhaseCount; p++) begin
      write_mode(p[0]);
      no_idle = (p == PhaseCount - 1);
      for (int unsigned k = 0; k < PhaseItems; k++) begin
        if (p == 3 && k == 100) wait_quiet(0);
        issue(pick_action(p % 3), TagW'($urandom), pick_time(), pick_time(), pick_time(),
              1'b0, '0);
      end
    end

    wait_quiet(20);
    $display("%0d requests in both modes: %0d round-robin and %0d FCFS executions",
             n_req, n_exec_rr, n_exec_fcfs);
    $display("%0d adds refused on a full queue, %0d empty-queue errors, %0d move marks seen",
             n_full, n_empty, n_marked);
    if (mismatches == 0) begin
      $display("rr_fcfs_ready_queue_unit test passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("rr_fcfs_ready_queue_unit test failed");
    end
    $finish;
  end

endmodule
